// ===== hw/rtl/bis_pkg.sv =====
// Shared types, codes and a helper function of the burner ignition sequencer.
`default_nettype none

package bis_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_CCW = 2'd2;

    // Reset value of the ignition angle.
    localparam logic [7:0] MAX_ANGLE_RST = 8'd180;

    // Burner phases, coded as they appear on the result beat.
    typedef enum logic [2:0] {
        PH_UNDEF  = 3'd0,
        PH_SW_ON  = 3'd1,
        PH_SW_OFF = 3'd2,
        PH_ON     = 3'd3,
        PH_OFF    = 3'd4
    } t_phase;

    // Payload of one request beat.
    typedef struct packed {
        logic [7:0]  requested_angle;
        logic        off_at_minimum;
        logic [31:0] now_ms;
    } t_req;

    // Payload of one servo write beat.
    typedef struct packed {
        logic [7:0] servo_angle;
        logic       dwell_after;
        logic [2:0] burner_phase;
        logic       last_of_run;
    } t_wr;

    // Configuration registers as one group.
    typedef struct packed {
        logic [7:0] min_angle;
        logic [7:0] max_angle;
        logic       mirror_ccw;
    } t_cfg;

    // Writes produced by one request: count and up to two beats in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_wr        w0;
        t_wr        w1;
    } t_step;

    // Angle as the servo sees it, mirrored for counter-clockwise mounting.
    function automatic logic [7:0] mirror_angle(input logic [7:0] value,
                                                input logic [7:0] max_angle,
                                                input logic       ccw);
        logic [7:0] d;
        d = value;
        if (ccw) begin
            d = (value > max_angle) ? 8'd0 : (max_angle - value);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bis_ifs.sv =====
// Handshake interfaces for the request and servo write channels.
`default_nettype none

interface bis_req_if;
    import bis_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bis_wr_if;
    import bis_pkg::*;

    logic valid;
    logic ready;
    t_wr  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bis_step.sv =====
// Next-state and servo write logic for one registered request.
`default_nettype none

module bis_step #(
    parameter int HOLD_OFF_MS = 5000,
    parameter int TIME_BITS   = 32
) (
    input  var bis_pkg::t_req        i_req,
    input  var bis_pkg::t_cfg        i_cfg,
    input  var bis_pkg::t_phase      i_phase,
    input  wire  [TIME_BITS-1:0]     i_last_ms,
    input  wire                      i_armed,
    input  wire  [7:0]               i_cur,
    output bis_pkg::t_phase          o_phase,
    output logic [TIME_BITS-1:0]     o_last_ms,
    output logic                     o_armed,
    output logic [7:0]               o_cur,
    output bis_pkg::t_step           o_step
);
    import bis_pkg::*;

    localparam logic [TIME_BITS-1:0] HOLD_CMP = TIME_BITS'(HOLD_OFF_MS);

    logic [7:0]           deg;
    logic                 on;
    logic                 armed_eff;
    logic [TIME_BITS-1:0] last_eff;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] diff;
    logic                 passed;
    logic                 steady;
    logic [7:0]           tgt;
    logic [7:0]           d_ign;
    logic [7:0]           d_tgt;
    logic                 en_ign;
    logic                 en_tgt;
    logic                 en_a;
    logic                 en_b;
    logic [7:0]           ang_a;
    logic                 dwl_a;
    t_phase               ph_new;

    // Clip the request and decide whether it asks for a lit burner.
    always_comb begin
        deg = i_req.requested_angle;
        if (deg < i_cfg.min_angle ||
            (i_req.off_at_minimum && deg == i_cfg.min_angle)) begin
            deg = 8'd0;
        end
        on  = (deg >= i_cfg.min_angle);
        tgt = on ? deg : 8'd0;
    end

    // The undefined phase disarms the hold-off so the first switch is immediate.
    always_comb begin
        armed_eff = (i_phase == PH_UNDEF) ? 1'b0 : i_armed;
        last_eff  = (i_phase == PH_UNDEF) ? '0 : i_last_ms;
        now       = i_req.now_ms[TIME_BITS-1:0];
        diff      = now - last_eff;
        passed    = !armed_eff || (diff > HOLD_CMP);
        steady    = (on && i_phase == PH_ON) || (!on && i_phase == PH_OFF);
    end

    // Servo angles and repeat suppression for the ignition and target writes.
    always_comb begin
        d_ign  = mirror_angle(i_cfg.max_angle, i_cfg.max_angle, i_cfg.mirror_ccw);
        d_tgt  = mirror_angle(tgt, i_cfg.max_angle, i_cfg.mirror_ccw);
        en_ign = (i_cfg.max_angle == 8'd0) || (i_cur != d_ign);
        en_tgt = (tgt == 8'd0) || (d_ign != d_tgt);
    end

    // Select the case: steady write, full switch, or waiting on the hold-off.
    always_comb begin
        o_last_ms = last_eff;
        o_armed   = armed_eff;
        o_cur     = i_cur;
        ph_new    = on ? PH_SW_ON : PH_SW_OFF;
        en_a      = 1'b0;
        en_b      = 1'b0;
        ang_a     = d_ign;
        dwl_a     = 1'b1;
        if (steady) begin
            ph_new = i_phase;
            en_a   = (tgt == 8'd0) || (i_cur != d_tgt);
            ang_a  = d_tgt;
            dwl_a  = 1'b0;
            o_cur  = d_tgt;
        end else if (passed) begin
            ph_new    = on ? PH_ON : PH_OFF;
            en_a      = en_ign;
            en_b      = en_tgt;
            o_cur     = d_tgt;
            o_last_ms = now;
            o_armed   = 1'b1;
        end
        o_phase = ph_new;
    end

    // Pack the enabled writes in order and mark the final one.
    always_comb begin
        o_step.w1.servo_angle  = d_tgt;
        o_step.w1.dwell_after  = 1'b0;
        o_step.w1.burner_phase = ph_new;
        o_step.w1.last_of_run  = 1'b1;
        o_step.w0.burner_phase = ph_new;
        if (en_a) begin
            o_step.cnt            = en_b ? 2'd2 : 2'd1;
            o_step.w0.servo_angle = ang_a;
            o_step.w0.dwell_after = dwl_a;
            o_step.w0.last_of_run = !en_b;
        end else begin
            o_step.cnt            = en_b ? 2'd1 : 2'd0;
            o_step.w0.servo_angle = d_tgt;
            o_step.w0.dwell_after = 1'b0;
            o_step.w0.last_of_run = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/burner_ignition_sequencer_core.sv =====
// Top level of the burner ignition sequencer: registers, write buffer and config port.
// A request beat is held in the input register until the output buffer can take its writes.
// Throughput: one request per cycle when each gives at most one write and the output is
// not stalled; a request that gives two writes holds the two-slot output buffer until its
// second beat leaves the single output port.
// Reset (synchronous, active low) clears the phase to undefined, the hold-off state,
// the current angle, the buffer and sets the config registers to their defaults.
`default_nettype none

module burner_ignition_sequencer_core #(
    parameter int HOLD_OFF_MS = 5000,
    parameter int TIME_BITS   = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [7:0]                    i_cfg_data,
    bis_req_if.sink                       i_req,
    bis_wr_if.source                      o_wr
);
    import bis_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_in_vld;
    t_req                 r_in;
    t_phase               r_phase;
    logic [TIME_BITS-1:0] r_last_ms;
    logic                 r_armed;
    logic [7:0]           r_cur;
    logic [1:0]           r_cnt;
    t_wr                  r_slot0;
    t_wr                  r_slot1;

    t_phase               n_phase;
    logic [TIME_BITS-1:0] n_last_ms;
    logic                 n_armed;
    logic [7:0]           n_cur;
    t_step                step;
    logic                 pop;
    logic                 can_load;
    logic                 consume;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_angle  <= 8'd0;
            r_cfg.max_angle  <= MAX_ANGLE_RST;
            r_cfg.mirror_ccw <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_ANGLE:  r_cfg.min_angle  <= i_cfg_data;
                CFG_MAX_ANGLE:  r_cfg.max_angle  <= i_cfg_data;
                CFG_MIRROR_CCW: r_cfg.mirror_ccw <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: the buffer must be free by the end of this cycle to take a request.
    assign pop           = o_wr.valid && o_wr.ready;
    assign can_load      = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign consume       = r_in_vld && can_load;
    assign i_req.ready   = !r_in_vld || consume;
    assign o_wr.valid    = (r_cnt != 2'd0);
    assign o_wr.data     = r_slot0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    bis_step #(
        .HOLD_OFF_MS (HOLD_OFF_MS),
        .TIME_BITS   (TIME_BITS)
    ) u_step (
        .i_req     (r_in),
        .i_cfg     (r_cfg),
        .i_phase   (r_phase),
        .i_last_ms (r_last_ms),
        .i_armed   (r_armed),
        .i_cur     (r_cur),
        .o_phase   (n_phase),
        .o_last_ms (n_last_ms),
        .o_armed   (n_armed),
        .o_cur     (n_cur),
        .o_step    (step)
    );

    // Burner state advances once per consumed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_UNDEF;
            r_last_ms <= '0;
            r_armed   <= 1'b0;
            r_cur     <= 8'd0;
        end else if (consume) begin
            r_phase   <= n_phase;
            r_last_ms <= n_last_ms;
            r_armed   <= n_armed;
            r_cur     <= n_cur;
        end
    end

    // Two-slot output buffer: load a whole run, or shift one beat out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (consume) begin
            r_cnt <= step.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_slot0 <= step.w0;
            r_slot1 <= step.w1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

    // The buffer never holds more than one run.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("write buffer count out of range");

    // A beat that does not close its run always has its partner behind it.
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && !o_wr.data.last_of_run) |-> (r_cnt == 2'd2))
        else $error("open run without a second beat");

    // The second beat of a run always closes it.
    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> r_slot1.last_of_run)
        else $error("second beat does not close the run");

    // The hold-off is only armed once the phase has left undefined.
    a_armed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_phase != PH_UNDEF))
        else $error("hold-off armed in undefined phase");

    // A dwell mark only ever goes with the ignition angle.
    a_dwell_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && o_wr.data.dwell_after) |-> (r_cnt == 2'd2 || o_wr.data.last_of_run))
        else $error("dwell mark out of place");

endmodule

`default_nettype wire
